// ===== hdl/dsu_pkg.sv =====
package dsu_pkg;

  localparam int unsigned NODE_W = 8;
  localparam int unsigned NODES  = 2 ** NODE_W;
  localparam int unsigned RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  typedef enum logic {
    ACT_FIND  = 1'b0,
    ACT_UNION = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_RANK_A,
    ST_RANK_B,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] rd_addr;
    logic              p_we;
    logic [NODE_W-1:0] p_waddr;
    logic [NODE_W-1:0] p_wdata;
    logic              r_we;
    logic [NODE_W-1:0] r_waddr;
    logic [RANK_W-1:0] r_wdata;
  } store_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [RANK_W-1:0] rank;
  } store_rsp_t;

endpackage

// ===== hdl/dsu_store.sv =====
module dsu_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsu_pkg::store_req_t req_i,
  output logic                ready_o,
  output dsu_pkg::store_rsp_t rsp_o
);

  logic [dsu_pkg::NODE_W-1:0] parent_mem [dsu_pkg::NODES];
  logic [dsu_pkg::RANK_W-1:0] rank_mem   [dsu_pkg::NODES];
  logic                       clear_q;
  logic [dsu_pkg::NODE_W-1:0] clear_idx_q;
  logic [dsu_pkg::NODE_W-1:0] pdata_q;
  logic [dsu_pkg::RANK_W-1:0] rdata_q;

  // After reset one entry per cycle is set to its own index with rank zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clear_idx_q <= '0;
    end else if (clear_q) begin
      clear_idx_q <= clear_idx_q + dsu_pkg::NODE_W'(1);
      if (&clear_idx_q) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      parent_mem[clear_idx_q] <= clear_idx_q;
      rank_mem[clear_idx_q]   <= '0;
    end else begin
      if (req_i.p_we) begin
        parent_mem[req_i.p_waddr] <= req_i.p_wdata;
      end
      if (req_i.r_we) begin
        rank_mem[req_i.r_waddr] <= req_i.r_wdata;
      end
    end
    pdata_q <= parent_mem[req_i.rd_addr];
    rdata_q <= rank_mem[req_i.rd_addr];
  end

  assign ready_o      = !clear_q;
  assign rsp_o.parent = pdata_q;
  assign rsp_o.rank   = rdata_q;

endmodule

// ===== hdl/dsu_ctrl.sv =====
module dsu_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_action_i,
  input  logic [dsu_pkg::NODE_W-1:0] in_node_a_i,
  input  logic [dsu_pkg::NODE_W-1:0] in_node_b_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dsu_pkg::NODE_W-1:0] out_root_a_o,
  output logic [dsu_pkg::NODE_W-1:0] out_root_b_o,
  output logic                       out_merged_o,
  input  logic                       store_ready_i,
  output dsu_pkg::store_req_t        req_o,
  input  dsu_pkg::store_rsp_t        rsp_i
);

  dsu_pkg::state_e state_q, state_d;
  logic                       action_q, action_d;
  logic [dsu_pkg::NODE_W-1:0] node_b_q, node_b_d;
  logic [dsu_pkg::NODE_W-1:0] start_q, start_d;
  logic [dsu_pkg::NODE_W-1:0] cur_q, cur_d;
  logic [dsu_pkg::NODE_W-1:0] root_q, root_d;
  logic [dsu_pkg::NODE_W-1:0] ra_q, ra_d;
  logic                       second_q, second_d;
  logic [dsu_pkg::RANK_W-1:0] rank_a_q, rank_a_d;
  logic                       merged_q, merged_d;
  logic                       out_valid_q, out_valid_d;
  logic [dsu_pkg::NODE_W-1:0] out_root_a_q, out_root_b_q;
  logic                       out_merged_q;
  logic                       out_load;
  logic                       node_eq;
  logic [dsu_pkg::NODE_W-1:0] cmp_lhs, cmp_rhs;

  // Shared equality unit used by both the root walk and the path rewrite.
  assign node_eq = (cmp_lhs == cmp_rhs);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    node_b_d    = node_b_q;
    start_d     = start_q;
    cur_d       = cur_q;
    root_d      = root_q;
    ra_d        = ra_q;
    second_d    = second_q;
    rank_a_d    = rank_a_q;
    merged_d    = merged_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    cmp_lhs     = cur_q;
    cmp_rhs     = root_q;
    req_o         = '0;
    req_o.rd_addr = cur_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dsu_pkg::ST_IDLE: begin
        in_ready_o = store_ready_i;
        if (in_valid_i && store_ready_i) begin
          action_d = in_action_i;
          node_b_d = in_node_b_i;
          start_d  = in_node_a_i;
          cur_d    = in_node_a_i;
          second_d = 1'b0;
          merged_d = 1'b0;
          state_d  = dsu_pkg::ST_WALK_RD;
        end
      end
      dsu_pkg::ST_WALK_RD: begin
        state_d = dsu_pkg::ST_WALK_CHK;
      end
      dsu_pkg::ST_WALK_CHK: begin
        cmp_lhs = rsp_i.parent;
        cmp_rhs = cur_q;
        if (node_eq) begin
          root_d  = cur_q;
          cur_d   = start_q;
          state_d = dsu_pkg::ST_CMP_RD;
        end else begin
          cur_d   = rsp_i.parent;
          state_d = dsu_pkg::ST_WALK_RD;
        end
      end
      dsu_pkg::ST_CMP_RD: begin
        if (node_eq) begin
          if (!second_q) begin
            ra_d = root_q;
            if (action_q == dsu_pkg::ACT_UNION) begin
              second_d = 1'b1;
              start_d  = node_b_q;
              cur_d    = node_b_q;
              state_d  = dsu_pkg::ST_WALK_RD;
            end else begin
              state_d = dsu_pkg::ST_DONE;
            end
          end else if (root_q != ra_q) begin
            state_d = dsu_pkg::ST_RANK_A;
          end else begin
            state_d = dsu_pkg::ST_DONE;
          end
        end else begin
          state_d = dsu_pkg::ST_CMP_WR;
        end
      end
      dsu_pkg::ST_CMP_WR: begin
        req_o.p_we    = 1'b1;
        req_o.p_waddr = cur_q;
        req_o.p_wdata = root_q;
        cur_d         = rsp_i.parent;
        state_d       = dsu_pkg::ST_CMP_RD;
      end
      dsu_pkg::ST_RANK_A: begin
        req_o.rd_addr = ra_q;
        state_d       = dsu_pkg::ST_RANK_B;
      end
      dsu_pkg::ST_RANK_B: begin
        req_o.rd_addr = root_q;
        rank_a_d      = rsp_i.rank;
        state_d       = dsu_pkg::ST_LINK;
      end
      dsu_pkg::ST_LINK: begin
        merged_d = 1'b1;
        req_o.p_we = 1'b1;
        priority if (rank_a_q < rsp_i.rank) begin
          req_o.p_waddr = ra_q;
          req_o.p_wdata = root_q;
        end else if (rsp_i.rank < rank_a_q) begin
          req_o.p_waddr = root_q;
          req_o.p_wdata = ra_q;
        end else begin
          req_o.p_waddr = root_q;
          req_o.p_wdata = ra_q;
          if (rank_a_q != dsu_pkg::RANK_MAX) begin
            req_o.r_we    = 1'b1;
            req_o.r_waddr = ra_q;
            req_o.r_wdata = rank_a_q + dsu_pkg::RANK_W'(1);
          end
        end
        state_d = dsu_pkg::ST_DONE;
      end
      dsu_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = dsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    node_b_q <= node_b_d;
    start_q  <= start_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    ra_q     <= ra_d;
    second_q <= second_d;
    rank_a_q <= rank_a_d;
    merged_q <= merged_d;
    if (out_load) begin
      out_root_a_q <= ra_q;
      out_root_b_q <= root_q;
      out_merged_q <= merged_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_root_a_o = out_root_a_q;
  assign out_root_b_o = out_root_b_q;
  assign out_merged_o = out_merged_q;

`ifndef ASSERT_OFF
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !req_o.p_we)
    else $error("parent write while taking a request");

  a_rank_with_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.r_we |-> (req_o.p_we && state_q == dsu_pkg::ST_LINK))
    else $error("rank write outside a link");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_merged_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_merged_q) |-> (out_root_a_q != out_root_b_q))
    else $error("merge reported with equal roots");
`endif

endmodule

// ===== hdl/disjoint_set_union_find.sv =====
// Channel  Direction  tdata (low bit up)          tuser
// s_axis   in         node_a[7:0], node_b[15:8]   action (0 find, 1 union)
// m_axis   out        root_a[7:0], root_b[15:8]   merged
//
// A find walks from the node up to its root, reading and checking each parent
// in turn, then walks the path again from the node, rewriting each parent to
// the root, confirms the root and loads the result. A union runs both walks,
// then the rank reads and the link, each step served by the single registered
// read port. After reset the store makes every node its own root, and
// s_axis_tready stays low until then; after that it is high only while idle.
// One request is in work at a time; the result register lets the next
// request in while a result waits on m_axis_tready.
module disjoint_set_union_find (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // node_a[7:0], node_b[15:8]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // root_a[7:0], root_b[15:8]
  output logic        m_axis_tuser   // merged
);

  dsu_pkg::store_req_t req;
  dsu_pkg::store_rsp_t rsp;
  logic                store_ready;

  dsu_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .ready_o (store_ready),
    .rsp_o   (rsp)
  );

  dsu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_node_a_i   (s_axis_tdata[7:0]),
    .in_node_b_i   (s_axis_tdata[15:8]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_root_a_o  (m_axis_tdata[7:0]),
    .out_root_b_o  (m_axis_tdata[15:8]),
    .out_merged_o  (m_axis_tuser),
    .store_ready_i (store_ready),
    .req_o         (req),
    .rsp_i         (rsp)
  );

endmodule
